FILE: src/zpconv_pkg.sv
// shared widths, codes and types of the zero padded 2d convolution block
package zpconv_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 6;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 7;
  localparam int KDIM_W    = 3;
  // window coordinates, sign bit on top: row index plus kernel offset stays below 256
  localparam int POS_W     = 9;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_KERNEL_DEF = 7;

  localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EVEN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd3;

  localparam logic [DIM_W-1:0]  IMAGE_ROWS_RST  = 7'd64;
  localparam logic [DIM_W-1:0]  IMAGE_COLS_RST  = 7'd64;
  localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = 3'd3;
  localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = 3'd3;

  // dimensions in use, already clamped to the store sizes
  typedef struct packed {
    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nc;
    logic [KDIM_W-1:0] kr;
    logic [KDIM_W-1:0] kc;
  } dims_t;

  // one kernel tap travelling along the multiply-accumulate pipeline
  typedef struct packed {
    logic valid;
    logic inb;
    logic first;
    logic last;
  } tap_t;

endpackage

FILE: src/zpconv_if.sv
// request and response channel interfaces of the convolution block
interface zpconv_in_if import zpconv_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, output func, output row, output col, output value,
                 input ready);
  modport sink(input valid, input func, input row, input col, input value,
               output ready);
endinterface

interface zpconv_out_if import zpconv_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic [STATUS_W-1:0]      status;

  modport source(output valid, output out_value, output out_row, output out_col,
                 output status, input ready);
  modport sink(input valid, input out_value, input out_row, input out_col,
               input status, output ready);
endinterface

FILE: src/zpconv_ram.sv
// synchronous memory, one write port and one registered read port
module zpconv_ram import zpconv_pkg::*;
  #(
  parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int AW    = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF),
  parameter int DW    = DATA_W
  ) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/zpconv_mac.sv
// multiply-accumulate pipeline: registered product, then wrapping accumulate
module zpconv_mac import zpconv_pkg::*;
  (
  input  logic              clk,
  input  logic              rst,
  input  tap_t              tap,
  input  logic [DATA_W-1:0] pixel,
  input  logic [DATA_W-1:0] coef,
  output logic [DATA_W-1:0] acc,
  output logic              done
);

  tap_t              tap2;
  logic [DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap2 <= '0;
      done <= 1'b0;
    end else begin
      tap2 <= tap;
      done <= tap2.valid && tap2.last;
    end
  end

  // low word of the product is all that survives the wrap
  always_ff @(posedge clk) begin
    prod <= tap.inb ? pixel * coef : '0;
    if (tap2.valid) begin
      acc <= tap2.first ? prod : acc + prod;
    end
  end

endmodule

FILE: src/zpconv_seq.sv
// sequencer: clearing pass, loads, tap walk over the window and result register
module zpconv_seq import zpconv_pkg::*;
  #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS,
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1,
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL,
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1
  ) (
  input  logic              clk,
  input  logic              rst,
  input  dims_t             dims,
  zpconv_in_if.sink         req,
  zpconv_out_if.source      rsp,
  output logic              img_we,
  output logic [IMG_AW-1:0] img_waddr,
  output logic [DATA_W-1:0] img_wdata,
  output logic [IMG_AW-1:0] img_raddr,
  output logic              ker_we,
  output logic [KER_AW-1:0] ker_waddr,
  output logic [DATA_W-1:0] ker_wdata,
  output logic [KER_AW-1:0] ker_raddr,
  output tap_t              tap,
  input  logic [DATA_W-1:0] mac_acc,
  input  logic              mac_done
);

  localparam int CLR_DEPTH = (IMG_DEPTH > KER_DEPTH) ? IMG_DEPTH : KER_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CLR_W-1:0]    clr_cnt;
  logic [KDIM_W-1:0]   ta, ta_next;
  logic [KDIM_W-1:0]   tb, tb_next;
  logic [IDX_W-1:0]    cur_row;
  logic [IDX_W-1:0]    cur_col;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic                accept;
  logic                clearing;
  logic                even_kernel;
  logic                out_of_range;
  logic                last_tap;
  logic                out_free;
  logic                out_load;
  logic [POS_W-1:0]    pr;
  logic [POS_W-1:0]    pc;
  logic                inb;

  assign clearing  = (state == S_CLEAR);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign even_kernel  = !dims.kr[0] || !dims.kc[0];
  assign out_of_range = ({1'b0, req.row} >= dims.nr) || ({1'b0, req.col} >= dims.nc);

  // window position of the current tap, negative when above or left of the image
  assign pr  = POS_W'(cur_row) + POS_W'(ta) - POS_W'(dims.kr >> 1);
  assign pc  = POS_W'(cur_col) + POS_W'(tb) - POS_W'(dims.kc >> 1);
  assign inb = !pr[POS_W-1] && !pc[POS_W-1] &&
               (pr[POS_W-2:0] < {1'b0, dims.nr}) && (pc[POS_W-2:0] < {1'b0, dims.nc});

  assign last_tap = (ta == dims.kr - 3'd1) && (tb == dims.kc - 3'd1);
  assign out_free = !out_valid || rsp.ready;
  assign out_load = ((state == S_DRAIN && mac_done) || state == S_HOLD) && out_free;

  // memory write ports: zero sweep after reset, otherwise load transactions
  always_comb begin
    if (clearing) begin
      img_we    = (int'(clr_cnt) < IMG_DEPTH);
      img_waddr = IMG_AW'(clr_cnt);
      img_wdata = '0;
      ker_we    = (int'(clr_cnt) < KER_DEPTH);
      ker_waddr = KER_AW'(clr_cnt);
      ker_wdata = '0;
    end else begin
      img_we    = accept && (req.func == FUNC_PIXEL) && !out_of_range;
      img_waddr = IMG_AW'(int'(req.row) * MAX_COLS + int'(req.col));
      img_wdata = req.value;
      ker_we    = accept && (req.func == FUNC_COEF) &&
                  ({3'b000, req.row} < {6'b0, dims.kr}) && ({3'b000, req.col} < {6'b0, dims.kc});
      ker_waddr = KER_AW'(int'(req.row) * MAX_KERNEL + int'(req.col));
      ker_wdata = req.value;
    end
  end

  assign img_raddr = inb ? IMG_AW'(int'(pr[POS_W-2:0]) * MAX_COLS + int'(pc[POS_W-2:0])) : '0;
  assign ker_raddr = KER_AW'(int'(ta) * MAX_KERNEL + int'(tb));

  always_comb begin
    state_next = state;
    ta_next    = ta;
    tb_next    = tb;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ta_next = '0;
        tb_next = '0;
        if (accept && req.func == FUNC_COMPUTE) begin
          state_next = (even_kernel || out_of_range) ? S_HOLD : S_RUN;
        end
      end
      S_RUN: begin
        if (tb == dims.kc - 3'd1) begin
          tb_next = '0;
          ta_next = ta + 3'd1;
        end else begin
          tb_next = tb + 3'd1;
        end
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_next = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      tap       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      tap.valid <= (state == S_RUN);
      tap.inb   <= (state == S_RUN) && inb;
      tap.first <= (ta == '0) && (tb == '0);
      tap.last  <= last_tap;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ta <= ta_next;
    tb <= tb_next;
    if (accept && req.func == FUNC_COMPUTE) begin
      cur_row <= req.row;
      cur_col <= req.col;
      if (even_kernel) begin
        res_status <= ST_EVEN;
      end else if (out_of_range) begin
        res_status <= ST_RANGE;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (out_load) begin
      rsp.out_value <= (res_status == ST_OK) ? mac_acc : '0;
      rsp.out_row   <= cur_row;
      rsp.out_col   <= cur_col;
      rsp.status    <= res_status;
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: src/zero_padded_conv2d.sv
// top level of the zero padded 2d convolution (correlation) block
// a compute result is registered after the taps walk the window and drain through the product
// and accumulate registers; a status error result skips the walk; loads are written when taken
// throughput: one tap per cycle through the single multiplier and image memory read port; a new
// request is taken only after the previous result is registered; one load per cycle while idle
// reset: synchronous; afterwards a sweep zeroes both stores before any request is taken
module zero_padded_conv2d import zpconv_pkg::*;
  #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
  ) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  zpconv_in_if.sink            req,
  zpconv_out_if.source         rsp
);

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  // largest dimension a register can name, bounded by the store size
  localparam int ROW_LIM   = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int COL_LIM   = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int KER_LIM   = (MAX_KERNEL < 7) ? MAX_KERNEL : 7;

  logic [DIM_W-1:0]  image_rows;
  logic [DIM_W-1:0]  image_cols;
  logic [KDIM_W-1:0] kernel_rows;
  logic [KDIM_W-1:0] kernel_cols;
  dims_t             dims;

  logic              img_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [DATA_W-1:0] img_wdata;
  logic [IMG_AW-1:0] img_raddr;
  logic [DATA_W-1:0] img_rdata;
  logic              ker_we;
  logic [KER_AW-1:0] ker_waddr;
  logic [DATA_W-1:0] ker_wdata;
  logic [KER_AW-1:0] ker_raddr;
  logic [DATA_W-1:0] ker_rdata;
  tap_t              tap;
  logic [DATA_W-1:0] mac_acc;
  logic              mac_done;

  // configuration registers; user must write only while no transaction in flight, unenforced
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= IMAGE_ROWS_RST;
      image_cols  <= IMAGE_COLS_RST;
      kernel_rows <= KERNEL_ROWS_RST;
      kernel_cols <= KERNEL_COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        REG_IMAGE_COLS:  image_cols  <= cfg_data;
        REG_KERNEL_ROWS: kernel_rows <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_COLS: kernel_cols <= cfg_data[KDIM_W-1:0];
      endcase
    end
  end

  // oversized dimensions act as the store size
  always_comb begin
    dims.nr = (image_rows > DIM_W'(ROW_LIM)) ? DIM_W'(ROW_LIM) : image_rows;
    dims.nc = (image_cols > DIM_W'(COL_LIM)) ? DIM_W'(COL_LIM) : image_cols;
    dims.kr = (kernel_rows > KDIM_W'(KER_LIM)) ? KDIM_W'(KER_LIM) : kernel_rows;
    dims.kc = (kernel_cols > KDIM_W'(KER_LIM)) ? KDIM_W'(KER_LIM) : kernel_cols;
  end

  // image store, row-major with a stride of MAX_COLS
  zpconv_ram #(
    .DEPTH (IMG_DEPTH),
    .AW    (IMG_AW),
    .DW    (DATA_W)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  // kernel store, row-major with a stride of MAX_KERNEL
  zpconv_ram #(
    .DEPTH (KER_DEPTH),
    .AW    (KER_AW),
    .DW    (DATA_W)
  ) u_ker_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (ker_wdata),
    .raddr (ker_raddr),
    .rdata (ker_rdata)
  );

  // walks the window, one tap per cycle; taps outside the image are masked to zero
  zpconv_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .req       (req),
    .rsp       (rsp),
    .img_we    (img_we),
    .img_waddr (img_waddr),
    .img_wdata (img_wdata),
    .img_raddr (img_raddr),
    .ker_we    (ker_we),
    .ker_waddr (ker_waddr),
    .ker_wdata (ker_wdata),
    .ker_raddr (ker_raddr),
    .tap       (tap),
    .mac_acc   (mac_acc),
    .mac_done  (mac_done)
  );

  // product and sum both wrap at 32 bits
  zpconv_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .tap   (tap),
    .pixel (img_rdata),
    .coef  (ker_rdata),
    .acc   (mac_acc),
    .done  (mac_done)
  );

endmodule

FILE: src/zpconv_checker.sv
// port level checks of the convolution block and their bind to the top level
module zpconv_checker import zpconv_pkg::*;
  (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [FUNC_W-1:0]   req_func,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [DATA_W-1:0]   rsp_value,
  input logic [STATUS_W-1:0] rsp_status
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // ready is low as soon as reset is released, at the start of the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing sweep");

  // error results carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
    else $error("error result with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EVEN || rsp_status == ST_RANGE))
    else $error("undefined status code");

  // loads and unused codes never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func != FUNC_COMPUTE |=> !$rose(rsp_valid))
    else $error("result after a non-compute transaction");

endmodule

bind zero_padded_conv2d zpconv_checker u_zpconv_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_func   (req.func),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.out_value),
  .rsp_status (rsp.status)
);
